/* sv/mbe_pkg.sv */
// ============================================================================
// mbe_pkg - shared types and constants for the Mandelbrot escape-time block
// Fixed-point widths, configuration codes and reset values, payload structs,
// and the command/status bundles between the controller and the datapath.
// ============================================================================
package mbe_pkg;

    // Algorithm constants
    localparam int MAX_ITER   = 256;
    localparam int FRAC_BITS  = 22;
    localparam int COORD_BITS = 12;

    // Configuration register widths
    localparam int SIZE_W  = 13;
    localparam int LIMIT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Output field widths
    localparam int PAL_W = 8;
    localparam int CNT_W = $clog2(MAX_ITER + 1);

    // Coordinate division: |p - size/2| fits MAG_W bits, dividend is MAG_W+FRAC_BITS
    localparam int NUM_W     = COORD_BITS + 2;
    localparam int MAG_W     = NUM_W - 1;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int R_W       = SIZE_W - 2;

    // c saturates at +-256 (FRAC_BITS+9 magnitude bits), z stays under 2^(FRAC_BITS+10)
    localparam int C_W    = FRAC_BITS + 10;
    localparam int Z_W    = FRAC_BITS + 12;
    localparam int MULT_W = FRAC_BITS + 5;
    localparam int PROD_W = 2 * MULT_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = SIZE_W'(640);
    localparam logic [LIMIT_W-1:0] RST_ESCAPE_LIMIT = LIMIT_W'(200);

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [PAL_W-1:0] palette_index;
        logic [CNT_W-1:0] iteration_count;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  frame_width;
        logic [SIZE_W-1:0]  frame_height;
        logic [LIMIT_W-1:0] escape_limit;
    } cfg_t;

    typedef struct packed {
        logic capture;    // latch the pixel
        logic div_load;   // start a division
        logic load_y;     // division operand: 0 = x, 1 = y
        logic div_step;   // one quotient bit
        logic c_store;    // store the signed, saturated quotient
        logic c_sel_y;    // store target: 0 = cx, 1 = cy
        logic iter_init;  // z = 0, n = 0
        logic iter_step;  // z = z^2 + c, n++
        logic finish;     // capture the result
    } cmd_t;

    typedef struct packed {
        logic stop;       // escaped or iteration cap reached
    } status_t;

endpackage

/* sv/mbe_dp.sv */
// ============================================================================
// mbe_dp - datapath of the Mandelbrot escape-time block
// Shared restoring divider for both c components, z iteration with three
// multipliers per step, escape check, and the result register.
// ============================================================================
module mbe_dp
(
    input  logic             clk,
    input  logic             rst_n,
    input  mbe_pkg::cfg_t    cfg,
    input  mbe_pkg::pixel_t  pixel,
    input  mbe_pkg::cmd_t    cmd,
    output mbe_pkg::status_t status,
    output mbe_pkg::result_t result
);

    localparam int F = mbe_pkg::FRAC_BITS;
    localparam logic [mbe_pkg::DVD_W-1:0] C_SAT = mbe_pkg::DVD_W'(256) << F;
    localparam logic signed [mbe_pkg::Z_W-1:0] Z_BIG = mbe_pkg::Z_W'(16) << F;

    // Pixel and coordinates
    mbe_pkg::pixel_t pix_reg;

    // Divider
    logic [mbe_pkg::SIZE_W-1:0]  min_size;
    logic [mbe_pkg::R_W-1:0]     r_raw, r_div;
    logic [mbe_pkg::COORD_BITS-1:0] p_sel;
    logic [mbe_pkg::SIZE_W-2:0]  half_sel;
    logic signed [mbe_pkg::NUM_W-1:0] num;
    logic [mbe_pkg::NUM_W-1:0]   num_abs;
    logic [mbe_pkg::MAG_W-1:0]   mag;
    logic [mbe_pkg::DVD_W-1:0]   dq_reg;
    logic [mbe_pkg::R_W-1:0]     rem_reg;
    logic                        neg_reg;
    logic [mbe_pkg::R_W:0]       rem_sh, rem_sub;
    logic                        q_bit;
    logic [mbe_pkg::DVD_W-1:0]   q_sat;
    logic signed [mbe_pkg::C_W-1:0] q_pos, c_val;
    logic signed [mbe_pkg::C_W-1:0] cx_reg, cy_reg;

    // Iteration
    logic signed [mbe_pkg::Z_W-1:0]    zx_reg, zy_reg, zx_next, zy_next;
    logic [mbe_pkg::CNT_W-1:0]         n_reg;
    logic signed [mbe_pkg::MULT_W-1:0] zx_m, zy_m;
    logic signed [mbe_pkg::PROD_W-1:0] sq_x, sq_y, xy, diff, diff_sh, xy_sh;
    logic [mbe_pkg::PROD_W-1:0]        sum_sq, lim_val;
    logic                              big, escaped;

    mbe_pkg::result_t result_reg;

    // Scale r = min(W,H)/4, never zero
    always_comb
    begin
        min_size = (cfg.frame_height < cfg.frame_width) ? cfg.frame_height : cfg.frame_width;
        r_raw    = min_size[mbe_pkg::SIZE_W-1:2];
        r_div    = (r_raw == '0) ? mbe_pkg::R_W'(1) : r_raw;
    end

    // Offset from the frame center
    always_comb
    begin
        p_sel    = cmd.load_y ? pix_reg.pixel_y : pix_reg.pixel_x;
        half_sel = cmd.load_y ? cfg.frame_height[mbe_pkg::SIZE_W-1:1]
                              : cfg.frame_width[mbe_pkg::SIZE_W-1:1];
        num      = $signed({2'b00, p_sel}) - $signed({1'b0, half_sel});
        num_abs  = num[mbe_pkg::NUM_W-1] ? mbe_pkg::NUM_W'(-num) : mbe_pkg::NUM_W'(num);
        mag      = num_abs[mbe_pkg::MAG_W-1:0];
    end

    // One restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[mbe_pkg::DVD_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_div});
        rem_sub = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    // Saturate and sign the quotient
    always_comb
    begin
        q_sat = (dq_reg > C_SAT) ? C_SAT : dq_reg;
        q_pos = $signed(q_sat[mbe_pkg::C_W-1:0]);
        c_val = neg_reg ? -q_pos : q_pos;
    end

    // z^2 + c and |z|^2 at full width
    always_comb
    begin
        zx_m    = zx_reg[mbe_pkg::MULT_W-1:0];
        zy_m    = zy_reg[mbe_pkg::MULT_W-1:0];
        sq_x    = zx_m * zx_m;
        sq_y    = zy_m * zy_m;
        xy      = zx_m * zy_m;
        diff    = sq_x - sq_y;
        diff_sh = diff >>> F;
        xy_sh   = xy >>> (F - 1);
        zx_next = mbe_pkg::Z_W'(cx_reg) + $signed(diff_sh[mbe_pkg::Z_W-1:0]);
        zy_next = mbe_pkg::Z_W'(cy_reg) + $signed(xy_sh[mbe_pkg::Z_W-1:0]);
        sum_sq  = $unsigned(sq_x) + $unsigned(sq_y);
        lim_val = mbe_pkg::PROD_W'(cfg.escape_limit) << (2 * F);
        big     = (zx_reg >= Z_BIG) || (zx_reg <= -Z_BIG) ||
                  (zy_reg >= Z_BIG) || (zy_reg <= -Z_BIG);
        escaped = big || (sum_sq >= lim_val);
    end

    assign status.stop = escaped || (n_reg == mbe_pkg::CNT_W'(mbe_pkg::MAX_ITER));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg    <= '0;
            dq_reg     <= '0;
            rem_reg    <= '0;
            neg_reg    <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            zx_reg     <= '0;
            zy_reg     <= '0;
            n_reg      <= '0;
            result_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                pix_reg <= pixel;
            end
            if (cmd.div_load)
            begin
                dq_reg  <= {mag, F'(0)};
                rem_reg <= '0;
                neg_reg <= num[mbe_pkg::NUM_W-1];
            end
            else if (cmd.div_step)
            begin
                dq_reg  <= {dq_reg[mbe_pkg::DVD_W-2:0], q_bit};
                rem_reg <= rem_sub[mbe_pkg::R_W-1:0];
            end
            if (cmd.c_store)
            begin
                if (cmd.c_sel_y)
                begin
                    cy_reg <= c_val;
                end
                else
                begin
                    cx_reg <= c_val;
                end
            end
            if (cmd.iter_init)
            begin
                zx_reg <= '0;
                zy_reg <= '0;
                n_reg  <= '0;
            end
            else if (cmd.iter_step)
            begin
                zx_reg <= zx_next;
                zy_reg <= zy_next;
                n_reg  <= n_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                result_reg.palette_index   <= mbe_pkg::PAL_W'(mbe_pkg::MAX_ITER - int'(n_reg));
                result_reg.iteration_count <= n_reg;
            end
        end
    end

    assign result = result_reg;

endmodule

/* sv/mbe_ctrl.sv */
// ============================================================================
// mbe_ctrl - sequencer of the Mandelbrot escape-time block
// Steps the datapath through both coordinate divisions and the iteration
// loop, and raises the result strobe.
// ============================================================================
module mbe_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mbe_pkg::status_t status,
    output mbe_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOAD_X,
        ST_DIV_X,
        ST_STORE_X,
        ST_DIV_Y,
        ST_STORE_Y,
        ST_ITER
    } state_t;

    localparam logic [mbe_pkg::DIV_CNT_W-1:0] CNT_LAST =
        mbe_pkg::DIV_CNT_W'(mbe_pkg::DIV_STEPS - 1);

    state_t                         state_reg, state_next;
    logic [mbe_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD_X;
                end
            end
            ST_LOAD_X:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_STORE_X;
                end
            end
            ST_STORE_X:
            begin
                cmd.c_store  = 1'b1;
                cmd.div_load = 1'b1;
                cmd.load_y   = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_STORE_Y;
                end
            end
            ST_STORE_Y:
            begin
                cmd.c_store   = 1'b1;
                cmd.c_sel_y   = 1'b1;
                cmd.iter_init = 1'b1;
                state_next    = ST_ITER;
            end
            ST_ITER:
            begin
                if (status.stop)
                begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.iter_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

/* sv/mandelbrot_escape_time_pixel_top.sv */
// ============================================================================
// mandelbrot_escape_time_pixel_top - escape-time index of one pixel
// Maps a pixel to a point c of the complex plane and iterates z = z^2 + c
// until |z|^2 reaches the escape limit or the iteration cap.
// ============================================================================
// A pixel beat is taken on a rising edge with start high and busy low. The
// block then works on that one pixel alone: a setup step, a shared
// restoring divider that forms cx and then cy at one quotient bit per cycle,
// each followed by a store step, then the iterations of z = z^2 + c and a
// final escape check. The iteration loop takes one complex step per cycle.
// The result beat shows on result for exactly one cycle with done high;
// the receiver cannot stall it, so capture it then. busy is already low in
// the strobe cycle, so the next pixel may be started right away.
// Configuration writes are always ready and take effect at once; write
// them only while busy is low.
// ============================================================================
module mandelbrot_escape_time_pixel_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Pixel channel
    input  logic                            start,
    input  mbe_pkg::pixel_t                 pixel,
    output logic                            busy,
    // Result channel
    output logic                            done,
    output mbe_pkg::result_t                result,
    // Configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mbe_pkg::cfg_t    cfg_reg;
    mbe_pkg::cmd_t    cmd;
    mbe_pkg::status_t status;

    // Registers never back-pressure a write.
    assign cfg_ready = 1'b1;

    // Hold the frame size and escape limit; drop writes to unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= mbe_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height <= mbe_pkg::RST_FRAME_HEIGHT;
            cfg_reg.escape_limit <= mbe_pkg::RST_ESCAPE_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mbe_pkg::CFG_FRAME_WIDTH:
                begin
                    cfg_reg.frame_width <= cfg_data[mbe_pkg::SIZE_W-1:0];
                end
                mbe_pkg::CFG_FRAME_HEIGHT:
                begin
                    cfg_reg.frame_height <= cfg_data[mbe_pkg::SIZE_W-1:0];
                end
                mbe_pkg::CFG_ESCAPE_LIMIT:
                begin
                    cfg_reg.escape_limit <= cfg_data[mbe_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: accepts the pixel beat, steps divisions and iterations.
    mbe_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Divider, iteration unit and result register.
    mbe_dp u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pixel  (pixel),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

/* sim/mandelbrot_escape_time_pixel_top_tb.sv */
// ============================================================================
// mandelbrot_escape_time_pixel_top_tb - self-checking bench for the pixel block
// Sends pixel beats under random start gaps and checks each result strobe
// against a fixed-point escape-time predictor that tracks the register
// settings. Walks several frame sizes and escape limits, extremes included.
// ============================================================================
module mandelbrot_escape_time_pixel_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles (no beat on any channel) before the run is declared hung.
    // The slowest result after its pixel beat, plus the longest start gap and
    // the register writes, stays well inside it, so this leaves a wide margin.
    localparam int QUIET_LIMIT    = 2000;
    // Settle time after the last result: one full worst-case pixel and more.
    localparam int TAIL_CYCLES    = 400;
    localparam int ITEMS_PER_SET  = 75;
    localparam int RANDOM_SETS    = 10;

    // Fixed-point limits: c saturates at +-256, a z component of 16 escapes
    localparam longint SAT_MAG    = longint'(256) <<< mbe_pkg::FRAC_BITS;
    localparam longint ESCAPE_MAG = longint'(16) <<< mbe_pkg::FRAC_BITS;

    typedef struct packed {
        mbe_pkg::pixel_t  px;
        mbe_pkg::result_t res;
    } escape_entry_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           start     = 1'b0;
    mbe_pkg::pixel_t                pixel     = '0;
    logic                           busy;
    logic                           done;
    mbe_pkg::result_t               result;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index = mbe_pkg::CFG_FRAME_WIDTH;
    logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Pixels waiting to be sent, and predicted results waiting for a strobe
    mbe_pkg::pixel_t pending_pixels[$];
    escape_entry_t   predicted_results[$];

    // Register copy used by the predictor, updated on every write beat
    mbe_pkg::cfg_t   cfg_shadow;

    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles    = 0;

    // Driver pacing
    int unsigned   gap_left       = 0;
    int unsigned   gap_draw;
    bit            gap_idle_only  = 1'b0;
    bit            burst          = 1'b0;

    // Monitor scratch
    bit            beat_seen;
    escape_entry_t want;

    mandelbrot_escape_time_pixel_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .pixel     (pixel),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Map one pixel coordinate onto the complex plane: (p - size/2) / r with
    // FRAC_BITS fraction bits, truncated toward zero, clipped to +-256.
    function automatic longint plane_coord(longint p, longint size, longint r);
        longint offset;
        longint mag;
        longint q;
        offset = p - (size >>> 1);
        mag    = (offset < 0) ? -offset : offset;
        q      = (mag <<< mbe_pkg::FRAC_BITS) / r;
        if (q > SAT_MAG)
            q = SAT_MAG;
        return (offset < 0) ? -q : q;
    endfunction

    // Escape-time count of one pixel under the given register settings.
    // Products are exact; each new z component drops its low FRAC_BITS bits
    // toward minus infinity, which is what an arithmetic shift does.
    function automatic mbe_pkg::result_t predict_escape(mbe_pkg::pixel_t px,
                                                        mbe_pkg::cfg_t cfg);
        longint           r;
        longint           cx;
        longint           cy;
        longint           zx;
        longint           zy;
        longint           nx;
        longint           ny;
        longint           limit_full;
        int               n;
        bit               escaped;
        mbe_pkg::result_t res;
        r = (cfg.frame_height < cfg.frame_width) ? longint'(cfg.frame_height)
                                                 : longint'(cfg.frame_width);
        r = r >>> 2;
        // Frames narrower than four pixels would give a zero scale: use one
        if (r == 0)
            r = 1;
        cx = plane_coord(longint'(px.pixel_x), longint'(cfg.frame_width), r);
        cy = plane_coord(longint'(px.pixel_y), longint'(cfg.frame_height), r);
        limit_full = longint'(cfg.escape_limit) <<< (2 * mbe_pkg::FRAC_BITS);
        zx = 0;
        zy = 0;
        n  = 0;
        // A zero limit is met by z = 0 itself, so no iteration runs
        escaped = (cfg.escape_limit == 0);
        while (!escaped && n < mbe_pkg::MAX_ITER)
        begin
            nx = cx + ((zx * zx - zy * zy) >>> mbe_pkg::FRAC_BITS);
            ny = cy + ((zx * zy) >>> (mbe_pkg::FRAC_BITS - 1));
            zx = nx;
            zy = ny;
            n++;
            // Any component at 16 or beyond is out, whatever the limit
            if (zx >= ESCAPE_MAG || zx <= -ESCAPE_MAG ||
                zy >= ESCAPE_MAG || zy <= -ESCAPE_MAG)
                escaped = 1'b1;
            else
                escaped = (zx * zx + zy * zy >= limit_full);
        end
        res.palette_index   = mbe_pkg::PAL_W'(mbe_pkg::MAX_ITER - n);
        res.iteration_count = mbe_pkg::CNT_W'(n);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: feed pixel beats from the pending queue
    // ------------------------------------------------------------------------
    // After each taken beat draw a random gap. Half the gaps count
    // from the beat itself, so start usually rises while the block is still
    // iterating and gets taken the cycle busy drops; the other half count
    // only cycles with busy low, so start also lands a little after the
    // block has gone idle. Burst stretches force gapless beats for a while.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else if (start && busy === 1'b0)
        begin
            if ($urandom_range(0, 15) == 0)
                burst = !burst;
            gap_draw = burst ? 0 : $urandom_range(0, 15);
            if (gap_draw == 0 && pending_pixels.size() != 0)
            begin
                // Keep start high and advance straight to the next pixel
                pixel <= pending_pixels.pop_front();
            end
            else
            begin
                start         <= 1'b0;
                gap_left      <= gap_draw;
                gap_idle_only <= $urandom_range(0, 1);
            end
        end
        else if (start)
        begin
            // Hold the beat until busy drops
        end
        else if (gap_left != 0)
        begin
            if (busy === 1'b0 || !gap_idle_only)
                gap_left <= gap_left - 1;
            // Toggle the pixel bus while start is low; the block must ignore it
            pixel <= mbe_pkg::pixel_t'($urandom);
        end
        else if (pending_pixels.size() != 0)
        begin
            pixel <= pending_pixels.pop_front();
            start <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check result strobes, predict on pixel beats, track writes
    // ------------------------------------------------------------------------
    // All three happen in this one process, in this order, so a strobe and a
    // new pixel beat on the same edge never race over the expected queue.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            cfg_shadow  = '{frame_width:  mbe_pkg::RST_FRAME_WIDTH,
                            frame_height: mbe_pkg::RST_FRAME_HEIGHT,
                            escape_limit: mbe_pkg::RST_ESCAPE_LIMIT};
            idle_cycles = 0;
        end
        else
        begin
            beat_seen = 1'b0;
            // Treat an unknown done as a strobe so it cannot slip by
            if (done !== 1'b0)
            begin
                beat_seen = 1'b1;
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result beat with none pending: palette %0d count %0d",
                                 $realtime, result.palette_index,
                                 result.iteration_count);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.palette_index !== want.res.palette_index ||
                        result.iteration_count !== want.res.iteration_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("%0t: pixel (%0d,%0d): expected palette %0d count %0d,",
                                   $realtime, want.px.pixel_x, want.px.pixel_y,
                                   want.res.palette_index, want.res.iteration_count);
                            $display(" got palette %0d count %0d",
                                     result.palette_index, result.iteration_count);
                        end
                    end
                end
            end
            if (start && busy === 1'b0)
            begin
                beat_seen = 1'b1;
                predicted_results.push_back('{px:  pixel,
                                              res: predict_escape(pixel, cfg_shadow)});
            end
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                beat_seen = 1'b1;
                case (cfg_index)
                    mbe_pkg::CFG_FRAME_WIDTH:
                        cfg_shadow.frame_width  = cfg_data[mbe_pkg::SIZE_W-1:0];
                    mbe_pkg::CFG_FRAME_HEIGHT:
                        cfg_shadow.frame_height = cfg_data[mbe_pkg::SIZE_W-1:0];
                    mbe_pkg::CFG_ESCAPE_LIMIT:
                        cfg_shadow.escape_limit = cfg_data[mbe_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            idle_cycles = beat_seen ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: end the run if no channel moves a beat for too long
    initial
    begin
        do
            @(negedge clk);
        while (idle_cycles < QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------

    task automatic queue_pixel(input int unsigned x, input int unsigned y);
        mbe_pkg::pixel_t px;
        px.pixel_x = mbe_pkg::COORD_BITS'(x);
        px.pixel_y = mbe_pkg::COORD_BITS'(y);
        pending_pixels.push_back(px);
    endtask

    // Block until every pixel has been sent and every result has come back.
    // Sample on the falling edge so the monitor's queue updates are settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || start === 1'b1 ||
               predicted_results.size() != 0);
    endtask

    task automatic write_register(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mbe_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // Only call with the block idle; leaves the caller on a falling edge
    task automatic apply_settings(input mbe_pkg::cfg_t cfg);
        write_register(mbe_pkg::CFG_FRAME_WIDTH,
                       mbe_pkg::CFG_DATA_W'(cfg.frame_width));
        write_register(mbe_pkg::CFG_FRAME_HEIGHT,
                       mbe_pkg::CFG_DATA_W'(cfg.frame_height));
        write_register(mbe_pkg::CFG_ESCAPE_LIMIT,
                       mbe_pkg::CFG_DATA_W'(cfg.escape_limit));
        @(negedge clk);
    endtask

    // Pick a coordinate for a frame dimension: mostly inside the frame where
    // the interesting orbits are, some on the edges, some anywhere at all.
    function automatic int unsigned pick_coord(int unsigned size);
        int unsigned last;
        int unsigned pick;
        last = (size == 0) ? 0 : ((size > 4096) ? 4095 : size - 1);
        case ($urandom_range(0, 9))
            0: pick = $urandom_range(0, 4095);
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       pick = 0;
                    1:       pick = last;
                    default: pick = 4095;
                endcase
            end
            default: pick = $urandom_range(0, last);
        endcase
        return pick;
    endfunction

    initial
    begin
        mbe_pkg::cfg_t plan;
        int unsigned   set_idx;
        int unsigned   k;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pixels at the reset settings (640 x 640, limit 200):
        // center and c = -1 stay bounded to the cap, c = 1 escapes
        // fast, plus corners, alternating bit patterns and points off frame.
        queue_pixel(320, 320);
        queue_pixel(160, 320);
        queue_pixel(480, 320);
        queue_pixel(0, 320);
        queue_pixel(320, 0);
        queue_pixel(0, 0);
        queue_pixel(639, 639);
        queue_pixel(4095, 4095);
        queue_pixel(0, 4095);
        queue_pixel(4095, 0);
        queue_pixel(12'hAAA, 12'h555);
        queue_pixel(12'h555, 12'hAAA);
        wait_drained();

        // Frame below four pixels: the scale drops to one and far pixels
        // saturate c at the 256 clamp
        plan = '{frame_width: 13'd3, frame_height: 13'd2, escape_limit: 8'd200};
        apply_settings(plan);
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(2, 0);
        queue_pixel(4095, 4095);
        wait_drained();

        // Zero escape limit: every pixel answers with no iteration at all
        plan = '{frame_width: 13'd640, frame_height: 13'd640, escape_limit: 8'd0};
        apply_settings(plan);
        queue_pixel(320, 320);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(160, 320);
        wait_drained();

        // Random pixels over a walk of settings: extremes first, then random.
        // Each set drains completely before the next writes, which also makes
        // the sender pause until every expected result is in.
        for (set_idx = 0; set_idx < RANDOM_SETS; set_idx++)
        begin
            case (set_idx)
                0: plan = '{frame_width: 13'd4,    frame_height: 13'd4,    escape_limit: 8'd4};
                1: plan = '{frame_width: 13'd4096, frame_height: 13'd4096, escape_limit: 8'd255};
                2: plan = '{frame_width: 13'd4096, frame_height: 13'd4,    escape_limit: 8'd200};
                3: plan = '{frame_width: 13'd4,    frame_height: 13'd4096, escape_limit: 8'd255};
                4: plan = '{frame_width: 13'd640,  frame_height: 13'd480,  escape_limit: 8'd4};
                default:
                begin
                    plan.frame_width  = mbe_pkg::SIZE_W'($urandom_range(4, 4096));
                    plan.frame_height = mbe_pkg::SIZE_W'($urandom_range(4, 4096));
                    plan.escape_limit = mbe_pkg::LIMIT_W'($urandom_range(4, 255));
                end
            endcase
            apply_settings(plan);
            for (k = 0; k < ITEMS_PER_SET; k++)
                queue_pixel(pick_coord(plan.frame_width), pick_coord(plan.frame_height));
            wait_drained();
        end

        // Let a stray late strobe show up before calling it
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/mbe_pkg.sv
sv/mbe_dp.sv
sv/mbe_ctrl.sv
sv/mandelbrot_escape_time_pixel_top.sv
sim/mandelbrot_escape_time_pixel_top_tb.sv
